// ----- design/dsb_pkg.sv -----
// ----------------------------------------------------------------------------
// dsb_pkg
// Shared constants, codes and control types for the delay-and-sum beamformer.
// ----------------------------------------------------------------------------
`default_nettype none

package dsb_pkg;

    localparam int ELEMENTS_DEF = 128;
    localparam int SAMPLES_DEF  = 4096;

    localparam int CMD_W     = 2;
    localparam int EL_IDX_W  = 7;
    localparam int SMP_IDX_W = 12;
    localparam int SMP_W     = 16;
    localparam int POS_W     = 20;
    localparam int DEPTH_W   = 20;
    localparam int MAG_W     = 23;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int ECNT_W     = 8;
    localparam int SCNT_W     = 13;
    localparam int SPU_W      = 24;

    localparam int RAD_W   = 58;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int PATH_W  = 30;
    localparam int PROD_W  = PATH_W + SPU_W;
    localparam int IDX_W   = PROD_W - 32;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    localparam logic [CMD_W-1:0] CMD_LOAD_POS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_RF  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PIXEL    = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_ELEMENT_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_COUNT   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLES_PER_UM = 2'd2;

    localparam logic [ECNT_W-1:0] ECNT_RST = 8'd128;
    localparam logic [SCNT_W-1:0] SCNT_RST = 13'd4096;
    localparam logic [SPU_W-1:0]  SPU_RST  = 24'd435760;

    typedef struct packed {
        logic ld_pos;
        logic ld_rf;
        logic pix_load;
        logic k_clr;
        logic k_inc;
        logic acc_clr;
        logic acc_en;
        logic pos_rd;
        logic dx_en;
        logic sq_en;
        logic sel_mag;
        logic sqrt_start;
        logic path_en;
        logic mul_en;
        logic fetch_en;
        logic out_en;
    } dp_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic last_elem;
        logic no_elem;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/dsb_sqrt.sv -----
// ----------------------------------------------------------------------------
// dsb_sqrt
// Shared integer square root, one result bit per cycle, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dsb_pkg::RAD_W-1:0]  radicand,
    output logic                            done,
    output logic [dsb_pkg::ROOT_W-1:0]      root
);
    import dsb_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    logic             take;

    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = rem_shift >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(ROOT_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (take)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ----- design/dsb_datapath.sv -----
// ----------------------------------------------------------------------------
// dsb_datapath
// Stores, config registers, delay arithmetic, echo accumulation and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_datapath #(
    parameter int ELEMENTS = dsb_pkg::ELEMENTS_DEF,
    parameter int SAMPLES  = dsb_pkg::SAMPLES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire dsb_pkg::dp_cmd_t                    ctl,
    output dsb_pkg::dp_stat_t                        stat,
    input  wire logic [dsb_pkg::EL_IDX_W-1:0]        element_index,
    input  wire logic [dsb_pkg::SMP_IDX_W-1:0]       sample_index,
    input  wire logic signed [dsb_pkg::SMP_W-1:0]    real_part,
    input  wire logic signed [dsb_pkg::SMP_W-1:0]    imag_part,
    input  wire logic signed [dsb_pkg::POS_W-1:0]    lateral_um,
    input  wire logic [dsb_pkg::DEPTH_W-1:0]         depth_um,
    input  wire logic                                cfg_we,
    input  wire logic [dsb_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [dsb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic [dsb_pkg::MAG_W-1:0]                magnitude
);
    import dsb_pkg::*;

    localparam int EW   = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int SW   = $clog2(SAMPLES);
    localparam int AW   = $clog2(ELEMENTS * SAMPLES);
    localparam int KW   = $clog2(ELEMENTS + 1);
    localparam int NSW  = $clog2(SAMPLES + 1);
    localparam int ACW  = 2 * SMP_W + 1 - SMP_W + EW;
    localparam int SQW  = (ACW > POS_W) ? ACW : POS_W;
    localparam int SUMW = 2 * SQW + 1;

    logic [ECNT_W-1:0] ecnt_reg;
    logic [SCNT_W-1:0] scnt_reg;
    logic [SPU_W-1:0]  spu_reg;

    logic signed [POS_W-1:0] pos_mem [ELEMENTS];
    logic [2*SMP_W-1:0]      rf_mem  [ELEMENTS*SAMPLES];

    logic signed [POS_W-1:0]   pix_lat_reg;
    logic [DEPTH_W-1:0]        pix_depth_reg;
    logic signed [POS_W-1:0]   pos_q_reg;
    logic [POS_W-1:0]          adx_reg;
    logic [2*SQW-1:0]          sqa_reg;
    logic [2*SQW-1:0]          sqb_reg;
    logic [PATH_W-1:0]         path_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      hit_reg;
    logic [2*SMP_W-1:0]        smp_q_reg;
    logic signed [ACW-1:0]     acc_re_reg;
    logic signed [ACW-1:0]     acc_im_reg;
    logic [KW-1:0]             k_reg;
    logic [MAG_W-1:0]          mag_reg;

    logic [KW-1:0]          ne;
    logic [NSW-1:0]         ns;
    logic                   pos_ok;
    logic                   rf_ok;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic signed [POS_W:0]  dx;
    logic [POS_W:0]         dx_abs;
    logic [ACW-1:0]         abs_re;
    logic [ACW-1:0]         abs_im;
    logic [SQW-1:0]         sq_in_a;
    logic [SQW-1:0]         sq_in_b;
    logic [SUMW-1:0]        sq_sum;
    logic [RAD_W-1:0]       radicand;
    logic                   sqrt_done;
    logic [ROOT_W-1:0]      root;
    logic [IDX_W-1:0]       idx;
    logic                   in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecnt_reg <= ECNT_RST;
            scnt_reg <= SCNT_RST;
            spu_reg  <= SPU_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ELEMENT_COUNT:  ecnt_reg <= cfg_wdata[ECNT_W-1:0];
                CFG_SAMPLE_COUNT:   scnt_reg <= cfg_wdata[SCNT_W-1:0];
                CFG_SAMPLES_PER_UM: spu_reg  <= cfg_wdata[SPU_W-1:0];
                default: ;
            endcase
        end
    end

    assign ne = (9'(ecnt_reg) >= 9'(ELEMENTS)) ? KW'(ELEMENTS) : KW'(ecnt_reg);
    assign ns = (17'(scnt_reg) >= 17'(SAMPLES)) ? NSW'(SAMPLES) : NSW'(scnt_reg);

    // loads
    assign pos_ok  = 9'(element_index) < 9'(ELEMENTS);
    assign rf_ok   = pos_ok && (17'(sample_index) < 17'(SAMPLES));
    assign wr_addr = AW'(32'(element_index) * 32'(SAMPLES) + 32'(sample_index));

    always_ff @(posedge clk)
    begin
        if (ctl.ld_pos && pos_ok)
        begin
            pos_mem[EW'(element_index)] <= lateral_um;
        end
        if (ctl.pos_rd)
        begin
            pos_q_reg <= pos_mem[k_reg[EW-1:0]];
        end
    end

    assign idx      = prod_reg[PROD_W-1 -: IDX_W];
    assign in_range = idx < IDX_W'(ns);
    assign rd_addr  = AW'(32'(k_reg) * 32'(SAMPLES) + 32'(idx[SW-1:0]));

    always_ff @(posedge clk)
    begin
        if (ctl.ld_rf && rf_ok)
        begin
            rf_mem[wr_addr] <= {imag_part, real_part};
        end
        if (ctl.fetch_en && in_range)
        begin
            smp_q_reg <= rf_mem[rd_addr];
        end
    end

    // per-element delay and pixel magnitude
    assign dx     = {pix_lat_reg[POS_W-1], pix_lat_reg} - {pos_q_reg[POS_W-1], pos_q_reg};
    assign dx_abs = dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
    assign abs_re = acc_re_reg[ACW-1] ? ACW'(-acc_re_reg) : ACW'(acc_re_reg);
    assign abs_im = acc_im_reg[ACW-1] ? ACW'(-acc_im_reg) : ACW'(acc_im_reg);
    assign sq_in_a = ctl.sel_mag ? SQW'(abs_re) : SQW'(pix_depth_reg);
    assign sq_in_b = ctl.sel_mag ? SQW'(abs_im) : SQW'(adx_reg);
    assign sq_sum  = SUMW'(sqa_reg) + SUMW'(sqb_reg);
    assign radicand = ctl.sel_mag ? RAD_W'(sq_sum) : (RAD_W'(sq_sum) << 16);

    dsb_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.pix_load)
        begin
            pix_lat_reg   <= lateral_um;
            pix_depth_reg <= depth_um;
        end
        if (ctl.dx_en)
        begin
            adx_reg <= dx_abs[POS_W-1:0];
        end
        if (ctl.sq_en)
        begin
            sqa_reg <= sq_in_a * sq_in_a;
            sqb_reg <= sq_in_b * sq_in_b;
        end
        if (ctl.path_en)
        begin
            path_reg <= (PATH_W'(pix_depth_reg) << 8) + PATH_W'(root);
        end
        if (ctl.mul_en)
        begin
            prod_reg <= PROD_W'(path_reg) * PROD_W'(spu_reg);
        end
        if (ctl.fetch_en)
        begin
            hit_reg <= in_range;
        end
        if (ctl.out_en)
        begin
            mag_reg <= (root > ROOT_W'(MAG_MAX)) ? MAG_MAX : root[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg      <= '0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else
        begin
            if (ctl.k_clr)
            begin
                k_reg <= '0;
            end
            else if (ctl.k_inc)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (ctl.acc_clr)
            begin
                acc_re_reg <= '0;
                acc_im_reg <= '0;
            end
            else if (ctl.acc_en && hit_reg)
            begin
                acc_re_reg <= acc_re_reg
                    + {{(ACW-SMP_W){smp_q_reg[SMP_W-1]}}, smp_q_reg[SMP_W-1:0]};
                acc_im_reg <= acc_im_reg
                    + {{(ACW-SMP_W){smp_q_reg[2*SMP_W-1]}}, smp_q_reg[2*SMP_W-1:SMP_W]};
            end
        end
    end

    assign stat.sqrt_done = sqrt_done;
    assign stat.last_elem = KW'(k_reg + 1'b1) == ne;
    assign stat.no_elem   = ne == '0;
    assign magnitude      = mag_reg;

endmodule

`default_nettype wire

// ----- design/dsb_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsb_ctrl
// Sequencer: issues loads, walks the elements of a pixel, then forms the magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dsb_pkg::CMD_W-1:0]  cmd,
    input  wire dsb_pkg::dp_stat_t          stat,
    output dsb_pkg::dp_cmd_t                ctl,
    output logic                            busy,
    output logic                            done
);
    import dsb_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_POS   = 14'b00000000000010,
        S_DX    = 14'b00000000000100,
        S_SQ    = 14'b00000000001000,
        S_SUM   = 14'b00000000010000,
        S_ROOT  = 14'b00000000100000,
        S_PATH  = 14'b00000001000000,
        S_MUL   = 14'b00000010000000,
        S_FETCH = 14'b00000100000000,
        S_ACC   = 14'b00001000000000,
        S_MSQ   = 14'b00010000000000,
        S_MSUM  = 14'b00100000000000,
        S_MROOT = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.ld_pos = cmd == CMD_LOAD_POS;
                    ctl.ld_rf  = cmd == CMD_LOAD_RF;
                    if (cmd == CMD_PIXEL)
                    begin
                        ctl.pix_load = 1'b1;
                        ctl.k_clr    = 1'b1;
                        ctl.acc_clr  = 1'b1;
                        state_next   = stat.no_elem ? S_MSQ : S_POS;
                    end
                end
            end
            S_POS:
            begin
                ctl.pos_rd = 1'b1;
                state_next = S_DX;
            end
            S_DX:
            begin
                ctl.dx_en  = 1'b1;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                ctl.sq_en  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                ctl.sqrt_start = 1'b1;
                state_next     = S_ROOT;
            end
            S_ROOT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = S_PATH;
                end
            end
            S_PATH:
            begin
                ctl.path_en = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                ctl.mul_en = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                ctl.fetch_en = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC:
            begin
                ctl.acc_en = 1'b1;
                ctl.k_inc  = 1'b1;
                state_next = stat.last_elem ? S_MSQ : S_POS;
            end
            S_MSQ:
            begin
                ctl.sel_mag = 1'b1;
                ctl.sq_en   = 1'b1;
                state_next  = S_MSUM;
            end
            S_MSUM:
            begin
                ctl.sel_mag    = 1'b1;
                ctl.sqrt_start = 1'b1;
                state_next     = S_MROOT;
            end
            S_MROOT:
            begin
                if (stat.sqrt_done)
                begin
                    ctl.out_en = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_OUT;

endmodule

`default_nettype wire

// ----- design/delay_and_sum_beamformer.sv -----
// ----------------------------------------------------------------------------
// delay_and_sum_beamformer
// Delay-and-sum beamformer: element position and RF sample stores, per-pixel
// delay computation and coherent summation, echo magnitude out.
// ----------------------------------------------------------------------------
//  channel  | signals                                          | handshake
//  ---------+--------------------------------------------------+--------------
//  item in  | cmd element_index sample_index real_part         | start & !busy
//           | imag_part lateral_um depth_um                    |
//  result   | magnitude                                        | done, 1 cycle
//  config   | cfg_addr cfg_wdata                               | cfg_we
//
//  Loads complete at the accepting edge and leave busy low. A pixel holds busy
//  from the accepting edge through the result strobe (element count saturated
//  at ELEMENTS): each element waits on the shared square-root unit (29 root
//  bits, then done) plus eight control steps, and the magnitude takes one
//  more root and three steps.
//  Reset idles the controller and loads the config registers with their defaults;
//  stores hold their contents undefined until written. The receiver cannot stall;
//  busy holds off further items until the result strobe has passed.
// ----------------------------------------------------------------------------
`default_nettype none

module delay_and_sum_beamformer #(
    parameter int ELEMENTS = dsb_pkg::ELEMENTS_DEF,
    parameter int SAMPLES  = dsb_pkg::SAMPLES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [dsb_pkg::CMD_W-1:0]           cmd,
    input  wire logic [dsb_pkg::EL_IDX_W-1:0]        element_index,
    input  wire logic [dsb_pkg::SMP_IDX_W-1:0]       sample_index,
    input  wire logic signed [dsb_pkg::SMP_W-1:0]    real_part,
    input  wire logic signed [dsb_pkg::SMP_W-1:0]    imag_part,
    input  wire logic signed [dsb_pkg::POS_W-1:0]    lateral_um,
    input  wire logic [dsb_pkg::DEPTH_W-1:0]         depth_um,
    output logic                                     done,
    output logic [dsb_pkg::MAG_W-1:0]                magnitude,
    input  wire logic                                cfg_we,
    input  wire logic [dsb_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [dsb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import dsb_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    dsb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    dsb_datapath #(
        .ELEMENTS (ELEMENTS),
        .SAMPLES  (SAMPLES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .element_index (element_index),
        .sample_index  (sample_index),
        .real_part     (real_part),
        .imag_part     (imag_part),
        .lateral_um    (lateral_um),
        .depth_um      (depth_um),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .magnitude     (magnitude)
    );

endmodule

`default_nettype wire

// ----- design/dsb_checker.sv -----
// ----------------------------------------------------------------------------
// dsb_sva
// Port-level checks on item acceptance and result strobing.
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_sva (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic [dsb_pkg::CMD_W-1:0]  cmd,
    input wire logic                       done
);
    import dsb_pkg::*;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a pixel");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd != CMD_PIXEL) |=> !busy)
        else $error("load item left block busy");

    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_PIXEL) |=> busy)
        else $error("pixel item not taken up");

    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("pixel ended without a result");

endmodule

bind delay_and_sum_beamformer dsb_sva u_dsb_sva (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
);

`default_nettype wire

// ----- sim/dsb_checker.sv -----
// ----------------------------------------------------------------------------
// dsb_checker
// Watches the item, config and result channels of the beamformer, keeps its
// own copy of the position and RF stores, predicts each pixel magnitude and
// compares it with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

package dsb_tb_pkg;

    localparam logic [dsb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // echo sample index for one element: (depth*256 + range) * spu / 2^32
    function automatic longint unsigned echo_index(logic signed [19:0] pix_lat,
                                                   logic signed [19:0] el_lat,
                                                   logic [19:0] depth,
                                                   logic [23:0] spu);
        longint dx;
        longint unsigned adx;
        longint unsigned d;
        longint unsigned el_range;
        longint unsigned path;
        dx       = longint'(pix_lat) - longint'(el_lat);
        adx      = (dx < 0) ? -dx : dx;
        d        = depth;
        el_range = root_floor((d * d + adx * adx) << 16);
        path     = (d << 8) + el_range;
        return (path * longint'(spu)) >> 32;
    endfunction

endpackage

module dsb_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic                                busy,
    input  wire logic [dsb_pkg::CMD_W-1:0]           cmd,
    input  wire logic [dsb_pkg::EL_IDX_W-1:0]        element_index,
    input  wire logic [dsb_pkg::SMP_IDX_W-1:0]       sample_index,
    input  wire logic signed [dsb_pkg::SMP_W-1:0]    real_part,
    input  wire logic signed [dsb_pkg::SMP_W-1:0]    imag_part,
    input  wire logic signed [dsb_pkg::POS_W-1:0]    lateral_um,
    input  wire logic [dsb_pkg::DEPTH_W-1:0]         depth_um,
    input  wire logic                                done,
    input  wire logic [dsb_pkg::MAG_W-1:0]           magnitude,
    input  wire logic                                cfg_we,
    input  wire logic [dsb_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [dsb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output int                                       fail_count,
    output int                                       pending,
    output int                                       pixels_checked
);
    import dsb_pkg::*;
    import dsb_tb_pkg::*;

    logic signed [POS_W-1:0] el_pos [ELEMENTS_DEF];
    logic [31:0]             rf_store [int];
    logic [ECNT_W-1:0]       elem_count;
    logic [SCNT_W-1:0]       samp_count;
    logic [SPU_W-1:0]        spu;
    logic [MAG_W-1:0]        mag_queue [$];

    assign pending = mag_queue.size();

    function automatic logic [MAG_W-1:0] pixel_magnitude(logic signed [POS_W-1:0] lat,
                                                         logic [DEPTH_W-1:0] depth);
        int              ne;
        int              ns;
        longint          acc_re;
        longint          acc_im;
        longint unsigned idx;
        longint unsigned mag;
        logic [31:0]     w;
        ne = (elem_count < ELEMENTS_DEF) ? elem_count : ELEMENTS_DEF;
        ns = (samp_count < SAMPLES_DEF) ? samp_count : SAMPLES_DEF;
        acc_re = 0;
        acc_im = 0;
        for (int k = 0; k < ne; k++) begin
            idx = echo_index(lat, el_pos[k], depth, spu);
            if (idx < ns) begin
                w = rf_store.exists(k * SAMPLES_DEF + int'(idx)) ?
                    rf_store[k * SAMPLES_DEF + int'(idx)] : 32'd0;
                acc_re += longint'($signed(w[15:0]));
                acc_im += longint'($signed(w[31:16]));
            end
        end
        if (acc_re < 0) acc_re = -acc_re;
        if (acc_im < 0) acc_im = -acc_im;
        mag = root_floor(acc_re * acc_re + acc_im * acc_im);
        if (mag > MAG_MAX)
            mag = MAG_MAX;
        return mag[MAG_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            elem_count <= ECNT_RST;
            samp_count <= SCNT_RST;
            spu        <= SPU_RST;
            fail_count <= 0;
            pixels_checked <= 0;
            mag_queue.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_ELEMENT_COUNT:  elem_count <= cfg_wdata[ECNT_W-1:0];
                    CFG_SAMPLE_COUNT:   samp_count <= cfg_wdata[SCNT_W-1:0];
                    CFG_SAMPLES_PER_UM: spu        <= cfg_wdata[SPU_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                case (cmd)
                    CMD_LOAD_POS: el_pos[element_index] = lateral_um;
                    CMD_LOAD_RF:  rf_store[int'(element_index) * SAMPLES_DEF
                                           + int'(sample_index)] = {imag_part, real_part};
                    CMD_PIXEL:    mag_queue.push_back(pixel_magnitude(lateral_um, depth_um));
                    default: ;
                endcase
            end
            if (done) begin
                if (mag_queue.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result: magnitude %0d", magnitude);
                end
                else begin
                    if (magnitude !== mag_queue[0]) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("magnitude mismatch: expected %0d, got %0d",
                                     mag_queue[0], magnitude);
                    end
                    void'(mag_queue.pop_front());
                    pixels_checked <= pixels_checked + 1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the delay-and-sum beamformer: element and RF loads, pixels
// whose echo taps are always loaded first, and a series of configurations
// including the extremes. Checking is done by dsb_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import dsb_pkg::*;
    import dsb_tb_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int ITEM_TARGET = 1750;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         cmd;
    logic [EL_IDX_W-1:0]      element_index;
    logic [SMP_IDX_W-1:0]     sample_index;
    logic signed [SMP_W-1:0]  real_part;
    logic signed [SMP_W-1:0]  imag_part;
    logic signed [POS_W-1:0]  lateral_um;
    logic [DEPTH_W-1:0]       depth_um;
    logic                     done;
    logic [MAG_W-1:0]         magnitude;
    logic                     cfg_we;
    logic [CFG_ADDR_W-1:0]    cfg_addr;
    logic [CFG_DATA_W-1:0]    cfg_wdata;
    int                       fail_count;
    int                       pending;
    int                       pixels_checked;

    int                       n_items;
    int                       n_cycles;
    logic signed [POS_W-1:0]  pos_loaded [ELEMENTS_DEF];
    bit                       rf_loaded [int];
    logic [ECNT_W-1:0]        elem_count;
    logic [SCNT_W-1:0]        samp_count;
    logic [SPU_W-1:0]         spu;

    delay_and_sum_beamformer dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .element_index(element_index), .sample_index(sample_index),
        .real_part(real_part), .imag_part(imag_part), .lateral_um(lateral_um),
        .depth_um(depth_um), .done(done), .magnitude(magnitude),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    dsb_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .element_index(element_index), .sample_index(sample_index),
        .real_part(real_part), .imag_part(imag_part), .lateral_um(lateral_um),
        .depth_um(depth_um), .done(done), .magnitude(magnitude),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending), .pixels_checked(pixels_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // log-spread value: small magnitudes are as likely as large ones
    function automatic logic [19:0] spread20();
        logic [19:0] v;
        v = $urandom;
        return v & ((20'd1 << $urandom_range(1, 20)) - 20'd1);
    endfunction

    task automatic send(input logic [CMD_W-1:0] c, input logic [EL_IDX_W-1:0] el,
                        input logic [SMP_IDX_W-1:0] si, input logic [SMP_W-1:0] re,
                        input logic [SMP_W-1:0] im, input logic [POS_W-1:0] lat,
                        input logic [DEPTH_W-1:0] dep);
        if (!(n_items >= 700 && n_items < 1000)) begin
            while ($urandom_range(99) < 18) begin
                @(negedge clk);
                start = 1'b0;
            end
        end
        @(negedge clk);
        cmd = c; element_index = el; sample_index = si;
        real_part = re; imag_part = im; lateral_um = lat; depth_um = dep;
        start = 1'b1;
        do @(posedge clk); while (busy);
        n_items++;
    endtask

    task automatic load_pos(input logic [EL_IDX_W-1:0] el, input logic [POS_W-1:0] lat);
        send(CMD_LOAD_POS, el, $urandom, $urandom, $urandom, lat, $urandom);
        pos_loaded[el] = lat;
    endtask

    task automatic load_rf(input logic [EL_IDX_W-1:0] el, input logic [SMP_IDX_W-1:0] si,
                           input logic [SMP_W-1:0] re, input logic [SMP_W-1:0] im);
        send(CMD_LOAD_RF, el, si, re, im, $urandom, $urandom);
        rf_loaded[int'(el) * SAMPLES_DEF + int'(si)] = 1'b1;
    endtask

    // loads each tap the pixel will read that is not loaded yet, then issues the pixel
    task automatic pixel(input logic [POS_W-1:0] lat, input logic [DEPTH_W-1:0] dep);
        int              ne;
        int              ns;
        longint unsigned idx;
        ne = (elem_count < ELEMENTS_DEF) ? elem_count : ELEMENTS_DEF;
        ns = (samp_count < SAMPLES_DEF) ? samp_count : SAMPLES_DEF;
        for (int k = 0; k < ne; k++) begin
            idx = echo_index(lat, pos_loaded[k], dep, spu);
            if (idx < ns && !rf_loaded.exists(k * SAMPLES_DEF + int'(idx)))
                load_rf(k, idx, $urandom, $urandom);
        end
        send(CMD_PIXEL, $urandom, $urandom, $urandom, $urandom, lat, dep);
    endtask

    task automatic write_cfg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        start = 1'b0;
        while (pending != 0 || busy) @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we = 1'b1; cfg_addr = a; cfg_wdata = d;
        @(negedge clk);
        cfg_we = 1'b0;
        case (a)
            CFG_ELEMENT_COUNT: elem_count = d[ECNT_W-1:0];
            CFG_SAMPLE_COUNT:  samp_count = d[SCNT_W-1:0];
            default:           spu = d[SPU_W-1:0];
        endcase
    endtask

    task automatic configure(input int ne, input int ns, input int s);
        write_cfg(CFG_ELEMENT_COUNT, ne);
        write_cfg(CFG_SAMPLE_COUNT, ns);
        write_cfg(CFG_SAMPLES_PER_UM, s);
    endtask

    task automatic random_pixel();
        if ($urandom_range(9) == 0)
            pixel($urandom, $urandom);
        else
            pixel(($urandom_range(1) ? -1 : 1) * int'(spread20() >> 1), spread20());
    endtask

    initial
    begin
        int r;
        rst_n = 1'b0; start = 1'b0; cmd = '0; element_index = '0; sample_index = '0;
        real_part = '0; imag_part = '0; lateral_um = '0; depth_um = '0;
        cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        n_items = 0; n_cycles = 0;
        elem_count = ECNT_RST; samp_count = SCNT_RST; spu = SPU_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every element gets a position; the ends take the field extremes
        for (int k = 0; k < ELEMENTS_DEF; k++)
            load_pos(k, (k == 0) ? -20'sd524288 : (k == 127) ? 20'sd524287
                     : (k - 64) * 300);
        send(CMD_UNUSED, '1, '1, '1, '1, '1, '1);
        load_rf(127, 4095, 16'h7FFF, 16'h8000);
        load_rf(0, 0, 16'h8000, 16'h7FFF);
        pixel(0, 20000);
        pixel(0, 0);
        pixel(-20'sd524288, 20'hFFFFF);

        // single element, spu zero: every element reads sample 0
        configure(1, 1, 0);
        for (int i = 0; i < 6; i++) random_pixel();
        // zero elements sums nothing
        configure(0, 100, 435760);
        for (int i = 0; i < 3; i++) random_pixel();
        // fastest spu pushes most taps out of range
        configure(8, 4096, 24'hFFFFFF);
        for (int i = 0; i < 15; i++) random_pixel();
        // counts above the store sizes saturate
        configure(255, 8191, 435760);
        for (int i = 0; i < 2; i++) random_pixel();
        configure(16, 8191, 1000000);
        for (int i = 0; i < 30; i++) random_pixel();
        configure(4, 64, 435760);

        while (n_items < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (n_items > 1100 && elem_count == 4)
                configure(6, 512, 200000);
            if (r < 65)
                random_pixel();
            else if (r < 80)
                load_rf($urandom, $urandom, $urandom, $urandom);
            else if (r < 92)
                load_pos($urandom_range(ELEMENTS_DEF - 1),
                         $urandom_range(1) ? $urandom : spread20());
            else
                send(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
        end

        @(negedge clk);
        start = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("%0d items sent, %0d pixel magnitudes checked over 8 configurations",
                 n_items, pixels_checked);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
